// File: sv/dvo_pkg.sv
// ----------------------------------------------------------------------------
// dvo_pkg
// Shared constants, month tables and the stage-to-stage record for the
// date check and day offset pipeline.
// ----------------------------------------------------------------------------
package dvo_pkg;

  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int YEAR_W  = 14;
  localparam int OFS_W   = 16;
  localparam int DOY_W   = 9;
  localparam int QY_W    = 8;   // whole years carried, at most 179
  localparam int Q100_W  = 8;   // year / 100, at most 163

  localparam logic [YEAR_W-1:0] YEAR_LOW      = 14'd1000;
  localparam logic [YEAR_W-1:0] YEAR_HIGH     = 14'd9999;
  localparam logic [DOY_W-1:0]  DAYS_PER_YEAR = 9'd365;

  // floor(v/365) = (v*RECIP_365) >> 24, exact for v < 2^16
  localparam logic [15:0] RECIP_365 = 16'd45965;
  localparam int          SH_365    = 24;
  // floor(v/100) = (v*RECIP_100) >> 19, exact for v < 2^14
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          SH_100    = 19;

  typedef struct packed {
    logic                 base_ok;   // all checks except the leap rule
    logic                 feb29;
    logic [YEAR_W-1:0]    year;
    logic [Q100_W-1:0]    q100;
    logic [DOY_W-1:0]     doy;
    logic [DOY_W-1:0]     rem;
    logic                 in_year;
    logic [DOY_W-1:0]     pos_near;
    logic [OFS_W-1:0]     r;
    logic [QY_W-1:0]      qy;
  } dvo_mid_t;

  // days in a month, 365-day table
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the months before m, 365-day table
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// File: sv/dvo_front.sv
// ----------------------------------------------------------------------------
// dvo_front
// First stage: range checks, day of year, offset split and the two
// reciprocal multiplies, registered into the mid record.
// ----------------------------------------------------------------------------
module dvo_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [dvo_pkg::MONTH_W-1:0]    month_in,
  input  logic [dvo_pkg::DAY_W-1:0]      day_in,
  input  logic [dvo_pkg::YEAR_W-1:0]     year_in,
  input  logic [dvo_pkg::OFS_W-1:0]      offset_days,
  output logic                           mid_valid,
  output dvo_pkg::dvo_mid_t              mid
);
  import dvo_pkg::*;

  logic [DAY_W-1:0]  mlen;
  logic              feb29;
  logic              base_ok;
  logic [DOY_W-1:0]  doy;
  logic [DOY_W-1:0]  rem;
  logic              in_year;
  logic [OFS_W-1:0]  r;
  logic [OFS_W-1:0]  near_sum;
  logic [31:0]       prod_y;
  logic [26:0]       prod_c;
  dvo_mid_t          mid_next;

  always_comb begin
    mlen     = month_len(month_in);
    feb29    = (month_in == 4'd2) && (day_in == 5'd29);
    base_ok  = (year_in >= YEAR_LOW) && (year_in <= YEAR_HIGH) &&
               (month_in >= 4'd1) && (month_in <= 4'd12) &&
               (day_in != 5'd0) && ((day_in <= mlen) || feb29);
    doy      = days_before(month_in) + {4'd0, day_in};
    rem      = DAYS_PER_YEAR - doy;
    in_year  = ({7'd0, rem} >= offset_days);
    // days past January 1 of the next year when the offset leaves the year
    r        = offset_days - {7'd0, rem} - 16'd1;
    near_sum = offset_days + {7'd0, doy};
    prod_y   = 32'(r) * 32'(RECIP_365);
    prod_c   = 27'(year_in) * 27'(RECIP_100);

    mid_next.base_ok  = base_ok;
    mid_next.feb29    = feb29;
    mid_next.year     = year_in;
    mid_next.q100     = prod_c[SH_100 +: Q100_W];
    mid_next.doy      = doy;
    mid_next.rem      = rem;
    mid_next.in_year  = in_year;
    mid_next.pos_near = near_sum[DOY_W-1:0];
    mid_next.r        = r;
    mid_next.qy       = prod_y[SH_365 +: QY_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    mid <= mid_next;
  end

endmodule

// File: sv/dvo_back.sv
// ----------------------------------------------------------------------------
// dvo_back
// Second stage: leap rule, position in the target year, month split and
// the result register.
// ----------------------------------------------------------------------------
module dvo_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           mid_valid,
  input  dvo_pkg::dvo_mid_t              mid,
  output logic                           done,
  output logic                           date_valid,
  output logic [dvo_pkg::DOY_W-1:0]      day_of_year,
  output logic [dvo_pkg::DOY_W-1:0]      days_remaining,
  output logic [dvo_pkg::MONTH_W-1:0]    month_out,
  output logic [dvo_pkg::DAY_W-1:0]      day_out,
  output logic [dvo_pkg::YEAR_W-1:0]     year_out
);
  import dvo_pkg::*;

  logic [14:0]        mul100;
  logic               div4;
  logic               div100;
  logic               div400;
  logic               leap;
  logic               ok;
  logic [OFS_W-1:0]   far_diff;
  logic [DOY_W-1:0]   pos;
  logic [YEAR_W-1:0]  yo;
  logic [MONTH_W-1:0] mo;
  logic [DOY_W-1:0]   day_wide;

  always_comb begin
    mul100   = 15'(mid.q100) * 15'd100;
    div4     = (mid.year[1:0] == 2'd0);
    div100   = (mul100 == {1'b0, mid.year});
    div400   = div100 && (mid.q100[1:0] == 2'd0);
    leap     = (div4 && !div100) || div400;
    ok       = mid.base_ok && (!mid.feb29 || leap);

    far_diff = mid.r - 16'(mid.qy) * 16'd365 + 16'd1;
    pos      = mid.in_year ? mid.pos_near : far_diff[DOY_W-1:0];
    yo       = mid.in_year ? mid.year : mid.year + 14'd1 + {6'd0, mid.qy};

    // month = 1 + number of month ends before pos (capped at December)
    mo = 4'd1;
    for (int i = 1; i < 12; i++) begin
      if (pos > days_before(4'(i + 1))) mo = mo + 4'd1;
    end
    day_wide = pos - days_before(mo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    date_valid     <= ok;
    day_of_year    <= ok ? mid.doy : '0;
    days_remaining <= ok ? mid.rem : '0;
    month_out      <= ok ? mo : '0;
    day_out        <= ok ? day_wide[DAY_W-1:0] : '0;
    year_out       <= ok ? yo : '0;
  end

endmodule

// File: sv/date_validate_and_offset.sv
// ----------------------------------------------------------------------------
// date_validate_and_offset
// Gregorian date check with day of year, days remaining and the date a
// given number of days later, carried on a 365-day year.
//
//  port group      dir  timing
//  start/busy      in/out transfer when start && !busy; busy stays low
//  month_in..      in   sampled with start
//  done            out  one-cycle strobe per result
//  date_valid..    out  valid while done is high
//
//  One item per cycle; each result passes the input register, the mid
//  register and the result register.
//  The two reciprocal multiplies and the month split are each followed
//  by a register.
//  Synchronous reset clears the pipeline valid bits; results in flight are
//  dropped. The receiver cannot stall, so no flow control is needed.
// ----------------------------------------------------------------------------
module date_validate_and_offset (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [dvo_pkg::MONTH_W-1:0]    month_in,
  input  logic [dvo_pkg::DAY_W-1:0]      day_in,
  input  logic [dvo_pkg::YEAR_W-1:0]     year_in,
  input  logic [dvo_pkg::OFS_W-1:0]      offset_days,
  output logic                           done,
  output logic                           date_valid,
  output logic [dvo_pkg::DOY_W-1:0]      day_of_year,
  output logic [dvo_pkg::DOY_W-1:0]      days_remaining,
  output logic [dvo_pkg::MONTH_W-1:0]    month_out,
  output logic [dvo_pkg::DAY_W-1:0]      day_out,
  output logic [dvo_pkg::YEAR_W-1:0]     year_out
);
  import dvo_pkg::*;

  logic               in_valid;
  logic [MONTH_W-1:0] month_r;
  logic [DAY_W-1:0]   day_r;
  logic [YEAR_W-1:0]  year_r;
  logic [OFS_W-1:0]   ofs_r;
  logic               mid_valid;
  dvo_mid_t           mid;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    month_r <= month_in;
    day_r   <= day_in;
    year_r  <= year_in;
    ofs_r   <= offset_days;
  end

  dvo_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .month_in    (month_r),
    .day_in      (day_r),
    .year_in     (year_r),
    .offset_days (ofs_r),
    .mid_valid   (mid_valid),
    .mid         (mid)
  );

  dvo_back u_back (
    .clk            (clk),
    .rst            (rst),
    .mid_valid      (mid_valid),
    .mid            (mid),
    .done           (done),
    .date_valid     (date_valid),
    .day_of_year    (day_of_year),
    .days_remaining (days_remaining),
    .month_out      (month_out),
    .day_out        (day_out),
    .year_out       (year_out)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("transfer did not produce a result three cycles later");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result strobe without a matching transfer");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !date_valid) |-> (day_of_year == '0) && (days_remaining == '0) &&
      (month_out == '0) && (day_out == '0) && (year_out == '0))
    else $error("invalid date with nonzero result fields");

  a_year_sum: assert property (@(posedge clk) disable iff (rst)
    (done && date_valid) |->
      (({1'b0, day_of_year} + {1'b0, days_remaining}) == 10'd365))
    else $error("day of year and days remaining do not sum to 365");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    (done && date_valid) |-> (month_out >= 4'd1) && (month_out <= 4'd12) &&
      (day_out >= 5'd1) && (day_out <= month_len(month_out)))
    else $error("offset date out of range");

endmodule

// File: bench/date_validate_and_offset_tb.sv
// ----------------------------------------------------------------------------
// date_validate_and_offset_tb
// Self-checking bench for the date check and day offset block. A short
// table of directed dates runs first, then randomly drawn dates, mostly
// valid ones with some offsets placed on year boundaries, plus malformed noise.
// Every result is checked field by field, in transfer order, against the
// result written in the table or a predictor of the 365-day-year offset arithmetic.
// ----------------------------------------------------------------------------
module date_validate_and_offset_tb;

  localparam int N_RANDOM  = 1400;
  localparam int N_STEADY  = 200;    // last transfers, sent without gaps
  localparam int TAIL_CYC  = 8;

  typedef struct packed {
    logic        valid;
    logic [8:0]  doy;
    logic [8:0]  rem;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [13:0] year;
  } date_res_t;

  typedef struct packed {
    logic [3:0]  m;
    logic [4:0]  d;
    logic [13:0] y;
    logic [15:0] x;
    logic        typed;    // expected result written out in the table
    date_res_t   res;
  } stim_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [dvo_pkg::MONTH_W-1:0] month_in;
  logic [dvo_pkg::DAY_W-1:0]   day_in;
  logic [dvo_pkg::YEAR_W-1:0]  year_in;
  logic [dvo_pkg::OFS_W-1:0]   offset_days;
  logic                        done;
  logic                        date_valid;
  logic [dvo_pkg::DOY_W-1:0]   day_of_year;
  logic [dvo_pkg::DOY_W-1:0]   days_remaining;
  logic [dvo_pkg::MONTH_W-1:0] month_out;
  logic [dvo_pkg::DAY_W-1:0]   day_out;
  logic [dvo_pkg::YEAR_W-1:0]  year_out;

  // expectation travels with the item it belongs to
  logic      known_row;
  date_res_t known_res;

  date_res_t pending_dates[$];
  stim_row_t stim_rows[$];
  date_res_t want;
  int        mismatch_count = 0;

  date_validate_and_offset dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .month_in       (month_in),
    .day_in         (day_in),
    .year_in        (year_in),
    .offset_days    (offset_days),
    .done           (done),
    .date_valid     (date_valid),
    .day_of_year    (day_of_year),
    .days_remaining (days_remaining),
    .month_out      (month_out),
    .day_out        (day_out),
    .year_out       (year_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 100000);
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned mdays(input int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return 28;
      default:               return 0;
    endcase
  endfunction

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic date_res_t date_of(input int unsigned ok, input int unsigned doy,
                                        input int unsigned rem, input int unsigned mo,
                                        input int unsigned dd, input int unsigned yy);
    date_res_t res;
    res.valid = ok[0];
    res.doy   = doy[8:0];
    res.rem   = rem[8:0];
    res.month = mo[3:0];
    res.day   = dd[4:0];
    res.year  = yy[13:0];
    return res;
  endfunction

  // date check, day of year and offset date on the fixed 365-day table
  function automatic date_res_t offset_date(input logic [3:0] m, input logic [4:0] d,
                                            input logic [13:0] y, input logic [15:0] x);
    date_res_t   res;
    int unsigned lim, doy, rem, pos, yo, r, mi;
    res = '0;
    lim = (m == 2 && leap_year(y)) ? 29 : mdays(m);
    if (y < 1000 || y > 9999 || d == 0 || d > lim) return res;
    doy = d;
    for (mi = 1; mi < m; mi++) doy += mdays(mi);
    rem = 365 - doy;
    if (x <= rem) begin
      yo  = y;
      pos = doy + x;
    end else begin
      r   = x - rem - 1;
      yo  = y + 1 + r / 365;
      pos = r % 365 + 1;
    end
    mi = 1;
    while (mi < 12 && pos > mdays(mi)) begin
      pos -= mdays(mi);
      mi++;
    end
    return date_of(1, doy, rem, mi, pos, yo);
  endfunction

  task automatic add_row(input int m, input int d, input int y, input int x,
                         input bit typed, input date_res_t res);
    stim_row_t row;
    row.m     = m[3:0];
    row.d     = d[4:0];
    row.y     = y[13:0];
    row.x     = x[15:0];
    row.typed = typed;
    row.res   = res;
    stim_rows.push_back(row);
  endtask

  // holds the item until the transfer edge; busy is steady between edges
  task automatic send_date(input int m, input int d, input int y, input int x,
                           input bit typed, input date_res_t res);
    start       <= 1'b1;
    month_in    <= m[3:0];
    day_in      <= d[4:0];
    year_in     <= y[13:0];
    offset_days <= x[15:0];
    known_row   <= typed;
    known_res   <= res;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic pause(input int n);
    start       <= 1'b0;
    month_in    <= 4'($urandom);
    day_in      <= 5'($urandom);
    year_in     <= 14'($urandom);
    offset_days <= 16'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  // transfer capture first, so a result in the same cycle as its transfer would still match
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      if (known_row) pending_dates.push_back(known_res);
      else pending_dates.push_back(offset_date(month_in, day_in, year_in, offset_days));
    end
    if (!rst && done) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: result with nothing pending, expected none got month %0d day %0d",
                 $time, month_out, day_out);
        mismatch_count++;
      end else begin
        want = pending_dates.pop_front();
        check_field("date_valid", want.valid, date_valid);
        check_field("day_of_year", want.doy, day_of_year);
        check_field("days_remaining", want.rem, days_remaining);
        check_field("month_out", want.month, month_out);
        check_field("day_out", want.day, day_out);
        check_field("year_out", want.year, year_out);
      end
    end
  end

  initial begin
    int        i, m, d, y, x, k, sel, rem0;
    stim_row_t row;
    date_res_t pred;
    rst         <= 1'b1;
    start       <= 1'b0;
    month_in    <= '0;
    day_in      <= '0;
    year_in     <= '0;
    offset_days <= '0;
    known_row   <= 1'b0;
    known_res   <= '0;

    // directed table
    add_row(1, 1, 1000, 0, 1, date_of(1, 1, 364, 1, 1, 1000));
    add_row(12, 31, 9999, 65535, 0, '0);
    add_row(12, 31, 1000, 65535, 0, '0);
    add_row(0, 1, 2000, 0, 1, '0);
    add_row(13, 1, 2000, 5, 1, '0);
    add_row(15, 31, 16383, 65535, 1, '0);
    add_row(1, 0, 2000, 0, 1, '0);
    add_row(4, 31, 2001, 0, 1, '0);
    add_row(1, 1, 999, 0, 1, '0);
    add_row(1, 1, 10000, 0, 1, '0);
    add_row(1, 1, 0, 0, 1, '0);
    // leap day: 400 rule, 100 rule, plain 4 rule, non-leap
    add_row(2, 29, 2000, 0, 1, date_of(1, 60, 305, 3, 1, 2000));
    add_row(2, 29, 1900, 0, 1, '0);
    add_row(2, 29, 2004, 400, 0, '0);
    add_row(2, 29, 2001, 0, 1, '0);
    add_row(2, 28, 2001, 1, 0, '0);
    // year boundaries, incl. landing exactly on Dec 31 of a later year
    add_row(12, 31, 2020, 0, 1, date_of(1, 365, 0, 12, 31, 2020));
    add_row(12, 31, 2020, 1, 1, date_of(1, 365, 0, 1, 1, 2021));
    add_row(1, 1, 2020, 364, 1, date_of(1, 1, 364, 12, 31, 2020));
    add_row(1, 1, 2020, 365, 1, date_of(1, 1, 364, 1, 1, 2021));
    add_row(12, 31, 2020, 365, 1, date_of(1, 365, 0, 12, 31, 2021));
    add_row(12, 31, 2020, 730, 0, '0);
    add_row(6, 15, 5000, 12345, 0, '0);
    add_row(7, 31, 9999, 32768, 0, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < stim_rows.size(); i++) begin
      row = stim_rows[i];
      if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 8));
      send_date(row.m, row.d, row.y, row.x, row.typed, row.res);
    end

    for (i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(0, 19);
      m = $urandom_range(1, 12);
      y = ($urandom_range(0, 4) == 0) ? 100 * $urandom_range(10, 99)
                                      : $urandom_range(1000, 9999);
      if (m == 2 && leap_year(y) && $urandom_range(0, 2) == 0) d = 29;
      else d = $urandom_range(1, mdays(m));
      if (sel == 0) begin
        // noise over the full field ranges
        m = $urandom_range(0, 15);
        d = $urandom_range(0, 31);
        y = $urandom_range(0, 16383);
      end else if (sel == 1) begin
        d = (mdays(m) + 1) % 32;
      end else if (sel == 2) begin
        y = $urandom_range(0, 1) ? $urandom_range(0, 999) : $urandom_range(10000, 16383);
      end

      pred = offset_date(m[3:0], d[4:0], y[13:0], 16'd0);
      rem0 = pred.rem;
      case ($urandom_range(0, 5))
        0: x = $urandom_range(0, rem0);
        1: x = rem0 + $urandom_range(0, 1);
        2: begin
          k = $urandom_range(1, (65535 - rem0) / 365);
          x = rem0 + 365 * k + $urandom_range(0, 1);
        end
        3: x = $urandom_range(0, 1000);
        default: x = $urandom_range(0, 65535);
      endcase
      if (x > 65535) x = 65535;

      if (i < N_RANDOM - N_STEADY && $urandom_range(0, 3) == 0) pause($urandom_range(1, 8));
      send_date(m, d, y, x, 0, '0);
    end

    pause(1);
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
